// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the raster block.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rdf_pkg.sv =====
// Shared types and constants of the raster draw and flood fill block.
// No dependencies; rdf_front, rdf_back and the top module import this package.
package rdf_pkg;

    localparam int          DEF_MAX_SIZE = 256;
    localparam int          SIZE_W       = 9;
    localparam int          COORD_IN_W   = 16;
    localparam int          CFG_IDX_W    = 2;
    localparam int          CMDQ_DEPTH   = 2;
    localparam int          RESQ_DEPTH   = 2;

    localparam logic [7:0]  COLOR_BLANK  = 8'd79;  // 'O'
    localparam logic [7:0]  COLOR_LO     = 8'd65;  // 'A'
    localparam logic [7:0]  COLOR_HI     = 8'd90;  // 'Z'
    localparam logic [SIZE_W-1:0] RESET_SIZE = 9'd250;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = 2'd1;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_PIXEL = 3'd1,
        OP_VLINE = 3'd2,
        OP_HLINE = 3'd3,
        OP_RECT  = 3'd4,
        OP_FILL  = 3'd5,
        OP_READ  = 3'd6,
        OP_NONE  = 3'd7
    } t_op;

    // Classified command as it travels from the front to the back
    typedef struct packed {
        t_op        op;
        logic       ign;
        logic [7:0] paint;
    } t_cmd_ctl;

    typedef struct packed {
        logic [7:0] pix;
        logic       ign;
    } t_result;

    typedef struct packed {
        logic init_busy;
        logic busy;
        logic stack_empty;
    } t_back_stat;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_SEED,
        ST_POP,
        ST_TOP,
        ST_NB_RD,
        ST_NB_CHK,
        ST_DONE
    } t_bstate;

endpackage

// ===== hdl/rdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/rdf_fifo.sv =====
// Small register queue used between the front, the back and the result port.
// No dependencies; DEPTH must be a power of two, at least 2.
module rdf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             wr_ok, rd_ok;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) r_wp <= r_wp + 1'b1;
            if (rd_ok) r_rp <= r_rp + 1'b1;
            if (wr_ok && !rd_ok)      r_cnt <= r_cnt + 1'b1;
            else if (rd_ok && !wr_ok) r_cnt <= r_cnt - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== hdl/rdf_front.sv =====
// Front end: validates and classifies each command and queues it for the back.
// Depends on rdf_pkg and rdf_fifo.
module rdf_front #(
    parameter int MAX_SIZE = rdf_pkg::DEF_MAX_SIZE,
    parameter int CW       = 8,
    parameter int QW       = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [2:0]                    i_operation,
    input  logic [rdf_pkg::COORD_IN_W-1:0] i_x_first,
    input  logic [rdf_pkg::COORD_IN_W-1:0] i_y_first,
    input  logic [rdf_pkg::COORD_IN_W-1:0] i_x_second,
    input  logic [rdf_pkg::COORD_IN_W-1:0] i_y_second,
    input  logic [7:0]                    i_paint,
    input  logic [rdf_pkg::SIZE_W-1:0]    i_width,
    input  logic [rdf_pkg::SIZE_W-1:0]    i_height,
    input  logic                          i_hold,
    input  logic                          i_cmd_pop,
    output logic [QW-1:0]                 o_cmd_data,
    output logic                          o_cmd_empty
);
    import rdf_pkg::*;

    t_op           op;
    t_cmd_ctl      ctl;
    logic          size_ok, paint_ok, paints;
    logic          xf_ok, yf_ok, xs_ok, ys_ok;
    logic [CW-1:0] xf, yf, xs, ys;
    logic [CW-1:0] x0, y0, x1, y1;
    logic          q_full;

    assign op = t_op'(i_operation);

    // range checks against the canvas size
    assign size_ok  = (i_width != '0) && (32'(i_width) <= MAX_SIZE) &&
                      (i_height != '0) && (32'(i_height) <= MAX_SIZE);
    assign paint_ok = (i_paint >= COLOR_LO) && (i_paint <= COLOR_HI);
    assign paints   = (op == OP_PIXEL) || (op == OP_VLINE) || (op == OP_HLINE) ||
                      (op == OP_RECT) || (op == OP_FILL);
    assign xf_ok = (i_x_first  != '0) && (32'(i_x_first)  <= 32'(i_width));
    assign yf_ok = (i_y_first  != '0) && (32'(i_y_first)  <= 32'(i_height));
    assign xs_ok = (i_x_second != '0) && (32'(i_x_second) <= 32'(i_width));
    assign ys_ok = (i_y_second != '0) && (32'(i_y_second) <= 32'(i_height));

    // zero-based coordinates; only meaningful once checked
    assign xf = CW'(i_x_first  - 1'b1);
    assign yf = CW'(i_y_first  - 1'b1);
    assign xs = CW'(i_x_second - 1'b1);
    assign ys = CW'(i_y_second - 1'b1);

    // classify: ignore flag and ordered bounds
    always_comb begin
        ctl.op    = op;
        ctl.paint = i_paint;
        ctl.ign   = 1'b0;
        priority if (!size_ok)                                 ctl.ign = 1'b1;
        else if (paints && !paint_ok)                          ctl.ign = 1'b1;
        else if (op != OP_CLEAR && op != OP_NONE && !(xf_ok && yf_ok))
                                                               ctl.ign = 1'b1;
        else if (op == OP_VLINE && !ys_ok)                     ctl.ign = 1'b1;
        else if (op == OP_HLINE && !xs_ok)                     ctl.ign = 1'b1;
        else if (op == OP_RECT && !(xs_ok && ys_ok))           ctl.ign = 1'b1;
        else if (op == OP_NONE)                                ctl.ign = 1'b1;
        else                                                   ctl.ign = 1'b0;

        x0 = xf; x1 = xf; y0 = yf; y1 = yf;
        if (op == OP_HLINE || op == OP_RECT) begin
            x0 = (xf < xs) ? xf : xs;
            x1 = (xf < xs) ? xs : xf;
        end
        if (op == OP_VLINE || op == OP_RECT) begin
            y0 = (yf < ys) ? yf : ys;
            y1 = (yf < ys) ? ys : yf;
        end
    end

    assign o_full = q_full || i_hold;

    rdf_fifo #(.WIDTH(QW), .DEPTH(CMDQ_DEPTH)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push && !o_full),
        .i_data  ({ctl, x0, y0, x1, y1}),
        .i_rd    (i_cmd_pop),
        .o_data  (o_cmd_data),
        .o_empty (o_cmd_empty),
        .o_full  (q_full)
    );
endmodule

// ===== hdl/rdf_back.sv =====
// Back end: canvas sweeps, line and box walks, reads and stack-based flood fill.
// Depends on rdf_pkg and rdf_ram.
module rdf_back #(
    parameter int MAX_SIZE = rdf_pkg::DEF_MAX_SIZE,
    parameter int CW       = 8,
    parameter int QW       = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rdf_pkg::SIZE_W-1:0] i_width,
    input  logic [rdf_pkg::SIZE_W-1:0] i_height,
    input  logic [QW-1:0]              i_cmd_data,
    input  logic                       i_cmd_empty,
    output logic                       o_cmd_pop,
    input  logic                       i_res_full,
    output logic                       o_res_push,
    output rdf_pkg::t_result           o_res,
    output rdf_pkg::t_back_stat        o_stat
);
    import rdf_pkg::*;

    localparam int AREA = MAX_SIZE * MAX_SIZE;
    localparam int AW   = (AREA > 1) ? $clog2(AREA) : 1;
    localparam int SCW  = $clog2(AREA + 1);

    t_bstate          r_state, n_state;
    t_cmd_ctl         cctl;
    logic [CW-1:0]    c_x0, c_y0, c_x1, c_y1;
    t_op              r_op;
    logic             r_ign;
    logic [7:0]       r_pix, r_paint, r_old;
    logic [CW-1:0]    r_x, r_y, r_xl, r_xh, r_yh;
    logic [CW-1:0]    r_cx, r_cy, r_nx, r_ny;
    logic [1:0]       r_k;
    logic [SCW-1:0]   r_cnt;
    logic [AW-1:0]    r_iaddr;

    logic             cnv_we, stk_we;
    logic [AW-1:0]    cnv_waddr, cnv_raddr, stk_waddr, stk_raddr;
    logic [7:0]       cnv_wdata, cnv_q;
    logic [2*CW-1:0]  stk_wdata, stk_q;
    logic             nb_ok;
    logic [CW-1:0]    nb_x, nb_y;
    logic             walk_end, seed_same, nb_match;

    function automatic logic [AW-1:0] pix_addr(logic [CW-1:0] x, logic [CW-1:0] y);
        pix_addr = AW'(AW'(y) * AW'(MAX_SIZE) + AW'(x));
    endfunction

    assign {cctl, c_x0, c_y0, c_x1, c_y1} = i_cmd_data;

    // neighbour of the current point selected by r_k (left, right, up, down)
    always_comb begin
        nb_x = r_cx;
        nb_y = r_cy;
        unique case (r_k)
            2'd0: begin nb_ok = (r_cx != '0); nb_x = r_cx - 1'b1; end
            2'd1: begin nb_ok = (32'(r_cx) + 1 < 32'(i_width)); nb_x = r_cx + 1'b1; end
            2'd2: begin nb_ok = (r_cy != '0); nb_y = r_cy - 1'b1; end
            default: begin nb_ok = (32'(r_cy) + 1 < 32'(i_height)); nb_y = r_cy + 1'b1; end
        endcase
    end

    assign walk_end  = (r_x == r_xh) && (r_y == r_yh);
    assign seed_same = (cnv_q == r_paint);
    assign nb_match  = (cnv_q == r_old);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT:   if (r_iaddr == AW'(AREA - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    if (cctl.ign) n_state = ST_DONE;
                    else if (cctl.op == OP_FILL || cctl.op == OP_READ) n_state = ST_SEED;
                    else n_state = ST_WALK;
                end
            end
            ST_WALK:   if (walk_end) n_state = ST_DONE;
            ST_SEED:   n_state = (r_op == OP_READ || seed_same) ? ST_DONE : ST_POP;
            ST_POP:    n_state = (r_cnt == '0) ? ST_DONE : ST_TOP;
            ST_TOP:    n_state = ST_NB_RD;
            ST_NB_RD: begin
                if (nb_ok)            n_state = ST_NB_CHK;
                else if (r_k == 2'd3) n_state = ST_POP;
            end
            ST_NB_CHK: n_state = (r_k == 2'd3) ? ST_POP : ST_NB_RD;
            ST_DONE:   if (!i_res_full) n_state = ST_IDLE;
            default:   n_state = ST_INIT;
        endcase
    end

    // memory strobes and handshakes
    always_comb begin
        cnv_we    = 1'b0;
        cnv_waddr = pix_addr(r_x, r_y);
        cnv_wdata = r_paint;
        cnv_raddr = pix_addr(c_x0, c_y0);
        stk_we    = 1'b0;
        stk_waddr = r_cnt[AW-1:0];
        stk_wdata = {r_cx, r_cy};
        stk_raddr = AW'(r_cnt - 1'b1);
        o_cmd_pop = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                cnv_we    = 1'b1;
                cnv_waddr = r_iaddr;
                cnv_wdata = COLOR_BLANK;
            end
            ST_IDLE:  o_cmd_pop = !i_cmd_empty;
            ST_WALK:  cnv_we = 1'b1;
            ST_SEED: begin
                if (r_op == OP_FILL && !seed_same) begin
                    cnv_we    = 1'b1;
                    cnv_waddr = pix_addr(r_cx, r_cy);
                    stk_we    = 1'b1;
                end
            end
            ST_NB_RD: cnv_raddr = pix_addr(nb_x, nb_y);
            ST_NB_CHK: begin
                cnv_waddr = pix_addr(r_nx, r_ny);
                stk_wdata = {r_nx, r_ny};
                if (nb_match) begin
                    cnv_we = 1'b1;
                    stk_we = 1'b1;
                end
            end
            ST_DONE:  o_res_push = !i_res_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_iaddr <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_INIT: r_iaddr <= r_iaddr + 1'b1;
                ST_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_op    <= cctl.op;
                        r_ign   <= cctl.ign;
                        r_pix   <= '0;
                        r_paint <= cctl.paint;
                        r_cx    <= c_x0;
                        r_cy    <= c_y0;
                        r_x     <= c_x0;
                        r_y     <= c_y0;
                        r_xl    <= c_x0;
                        r_xh    <= c_x1;
                        r_yh    <= c_y1;
                        if (cctl.op == OP_CLEAR) begin
                            r_paint <= COLOR_BLANK;
                            r_x     <= '0;
                            r_y     <= '0;
                            r_xl    <= '0;
                            r_xh    <= CW'(i_width - 1'b1);
                            r_yh    <= CW'(i_height - 1'b1);
                        end
                    end
                end
                ST_WALK: begin
                    if (r_x == r_xh) begin
                        r_x <= r_xl;
                        r_y <= r_y + 1'b1;
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                ST_SEED: begin
                    r_old <= cnv_q;
                    if (r_op == OP_READ) r_pix <= cnv_q;
                    else if (seed_same)  r_ign <= 1'b1;
                    else                 r_cnt <= r_cnt + 1'b1;
                end
                ST_POP: if (r_cnt != '0) r_cnt <= r_cnt - 1'b1;
                ST_TOP: begin
                    {r_cx, r_cy} <= stk_q;
                    r_k <= 2'd0;
                end
                ST_NB_RD: begin
                    r_nx <= nb_x;
                    r_ny <= nb_y;
                    if (!nb_ok) r_k <= r_k + 1'b1;
                end
                ST_NB_CHK: begin
                    if (nb_match) r_cnt <= r_cnt + 1'b1;
                    r_k <= r_k + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_res.pix = r_ign ? 8'd0 : r_pix;
    assign o_res.ign = r_ign;

    assign o_stat.init_busy   = (r_state == ST_INIT);
    assign o_stat.busy        = (r_state != ST_IDLE) && (r_state != ST_INIT);
    assign o_stat.stack_empty = (r_cnt == '0);

    rdf_ram #(.WIDTH(8), .DEPTH(AREA)) u_canvas (
        .i_clk   (i_clk),
        .i_we    (cnv_we),
        .i_waddr (cnv_waddr),
        .i_wdata (cnv_wdata),
        .i_raddr (cnv_raddr),
        .o_rdata (cnv_q)
    );

    rdf_ram #(.WIDTH(2*CW), .DEPTH(AREA)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );
endmodule

// ===== hdl/raster_draw_and_flood_fill_top.sv =====
// Raster canvas with drawing commands and 4-connected flood fill.
// Channels: command queue input (push/full), result queue output (empty/pop),
// configuration write port (i_cfg_valid/o_cfg_ready) for canvas width/height.
// Every command yields one result: pixel_value (read colour, else zero), ignored.
// After reset the back end blanks all MAX_SIZE*MAX_SIZE pixels (65536 at the
// default) of the canvas to 'O', one pixel per cycle, with full held high.
// Steps per command, from the back end taking it:
//   ignored: straight to the result; read: one canvas read; pixel/lines/
//   rectangle/clear: one write per pixel, row by row; flood fill: paint the
//   seed, pop each point, probe its four neighbours and paint and push those
//   in range in the old colour, paced by the single canvas read port and stack RAM.
// One command is carried out at a time; a two-entry queue lets the next
// commands be accepted while one runs. Results wait in a two-entry queue; if
// the receiver does not pop, the back end stalls and then full rises.
// Configuration writes take effect at once and do not clear the canvas.
// Depends on rdf_pkg, rdf_front, rdf_back, rdf_fifo, rdf_ram, assert_macros.svh.
`include "assert_macros.svh"
module raster_draw_and_flood_fill_top #(
    parameter int MAX_SIZE = rdf_pkg::DEF_MAX_SIZE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [2:0]                     i_operation,
    input  logic [rdf_pkg::COORD_IN_W-1:0] i_x_first,
    input  logic [rdf_pkg::COORD_IN_W-1:0] i_y_first,
    input  logic [rdf_pkg::COORD_IN_W-1:0] i_x_second,
    input  logic [rdf_pkg::COORD_IN_W-1:0] i_y_second,
    input  logic [7:0]                     i_paint,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_pixel_value,
    output logic                           o_ignored,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rdf_pkg::SIZE_W-1:0]     i_cfg_data
);
    import rdf_pkg::*;

    localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int QW = $bits(t_cmd_ctl) + 4 * CW;

    logic [SIZE_W-1:0] r_width, r_height;
    logic [QW-1:0]     cmd_data;
    logic              cmd_empty, cmd_pop;
    logic              res_full, res_push;
    t_result           res, res_q;
    t_back_stat        stat;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_SIZE;
            r_height <= RESET_SIZE;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_WIDTH_IDX)  r_width  <= i_cfg_data;
            if (i_cfg_index == CFG_HEIGHT_IDX) r_height <= i_cfg_data;
        end
    end

    rdf_front #(.MAX_SIZE(MAX_SIZE), .CW(CW), .QW(QW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_operation (i_operation),
        .i_x_first   (i_x_first),
        .i_y_first   (i_y_first),
        .i_x_second  (i_x_second),
        .i_y_second  (i_y_second),
        .i_paint     (i_paint),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_hold      (stat.init_busy),
        .i_cmd_pop   (cmd_pop),
        .o_cmd_data  (cmd_data),
        .o_cmd_empty (cmd_empty)
    );

    rdf_back #(.MAX_SIZE(MAX_SIZE), .CW(CW), .QW(QW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_cmd_data  (cmd_data),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res),
        .o_stat      (stat)
    );

    // result queue
    rdf_fifo #(.WIDTH($bits(t_result)), .DEPTH(RESQ_DEPTH)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_data  (res),
        .i_rd    (pop),
        .o_data  (res_q),
        .o_empty (empty),
        .o_full  (res_full)
    );

    assign o_pixel_value = res_q.pix;
    assign o_ignored     = res_q.ign;

    // checks
    `RDF_ASSERT_NOW(a_init_blocks, stat.init_busy, full, "command taken during canvas blanking")
    `RDF_ASSERT_NOW(a_stack_idle, !stat.busy, stat.stack_empty, "fill stack not empty when idle")
    `RDF_ASSERT_NOW(a_ign_zero, !empty && o_ignored, o_pixel_value == 8'd0, "ignored result carries a colour")
    `RDF_ASSERT_NEXT(a_push_room, res_push, !empty, "result lost on push")
endmodule
